>>> rtl/core/string_position_hash_assert.svh
// assertion macros for the string position hash block
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef STRING_POSITION_HASH_ASSERT_SVH
`define STRING_POSITION_HASH_ASSERT_SVH

`ifndef SYNTHESIS
// clocked on clk, disabled while arst_n is low
`define SPH_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// clocked on clk, checked during reset too
`define SPH_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPH_ASSERT(label, prop, msg)
`define SPH_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

>>> rtl/core/sph_pkg.sv
// types and constants shared by the string position hash block
// no dependencies
package sph_pkg;

	localparam logic [31:0] HASH_MODULUS   = 32'h8000_000b;
	localparam logic [31:0] HASH_MULT      = 32'hffff_ffef;
	localparam logic [31:0] HASH_FINAL_XOR = 32'h1234_5678;
	localparam logic [7:0]  CASE_OFFSET    = 8'h20;

	localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z  = 8'h5a;
	localparam logic [7:0] CHAR_SLASH    = 8'h2f;
	localparam logic [7:0] CHAR_BSLASH   = 8'h5c;

	localparam logic [1:0] CFG_HASH_MODE    = 2'd0;
	localparam logic [1:0] CFG_SIGNED_CHARS = 2'd1;

	localparam logic [1:0] MODE_PLAIN = 2'd0;

	typedef struct packed {
		logic [1:0] hash_mode;
		logic       signed_chars;
	} sph_cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WEIGHT,
		ST_REDUCE,
		ST_SCRAMBLE,
		ST_STORE,
		ST_FINISH
	} sph_state_t;

endpackage

>>> rtl/core/string_position_hash.sv
// string position hash: one character per item, sequencer around a shared multiplier
// depends on sph_pkg, sph_char_widen, sph_mul and string_position_hash_assert.svh
// character item: two multiplier passes (weight, scramble) before the next acceptance
// end item: after any character passes, finish posts the result when out_free
// idle item without character: stays in idle; result register frees input while waiting
// arst_n clears hash, position, sequencer and output valid; hash_mode 0, signed_chars 1
`include "string_position_hash_assert.svh"
module string_position_hash
	import sph_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_byte,
	input  logic        end_of_string,
	input  logic        no_char,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] hash_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [1:0]  cfg_data
);

	sph_state_t  state_q;
	sph_state_t  state_d;
	sph_cfg_t    cfg_q;
	logic [7:0]  byte_q;
	logic        eos_q;
	logic [31:0] hash_q;
	logic [31:0] pos_q;
	logic        out_valid_q;
	logic [31:0] hash_value_q;

	logic        in_fire;
	logic        out_free;
	logic        finish_fire;
	logic        sel_scramble;
	logic        load_sum;
	logic        load_prod;
	logic [31:0] char_wide;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] prod_q;
	logic [31:0] sum;
	logic [31:0] reduced;

	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid & in_ready;
	assign out_free  = ~out_valid_q | out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (!no_char) begin
						state_d = ST_WEIGHT;
					end else if (end_of_string) begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_WEIGHT:   state_d = ST_REDUCE;
			ST_REDUCE:   state_d = ST_SCRAMBLE;
			ST_SCRAMBLE: state_d = ST_STORE;
			ST_STORE:    state_d = eos_q ? ST_FINISH : ST_IDLE;
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready     = 1'b0;
		sel_scramble = 1'b0;
		load_sum     = 1'b0;
		load_prod    = 1'b0;
		finish_fire  = 1'b0;
		unique case (state_q)
			ST_IDLE:     in_ready = 1'b1;
			ST_WEIGHT:   ;
			ST_REDUCE:   load_sum = 1'b1;
			ST_SCRAMBLE: sel_scramble = 1'b1;
			ST_STORE:    load_prod = 1'b1;
			ST_FINISH:   finish_fire = out_free;
			default:     ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hash_mode    <= MODE_PLAIN;
			cfg_q.signed_chars <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_HASH_MODE:    cfg_q.hash_mode <= cfg_data;
				CFG_SIGNED_CHARS: cfg_q.signed_chars <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_q <= char_byte;
			eos_q  <= end_of_string;
		end
	end

	sph_char_widen u_widen (
		.cfg       (cfg_q),
		.char_in   (byte_q),
		.char_wide (char_wide)
	);

	assign mul_a = sel_scramble ? hash_q : pos_q + 32'd1;
	assign mul_b = sel_scramble ? HASH_MULT : char_wide;

	sph_mul u_mul (
		.clk    (clk),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod_q (prod_q)
	);

	assign sum     = hash_q + prod_q;
	assign reduced = (sum >= HASH_MODULUS) ? sum - HASH_MODULUS : sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
			pos_q  <= '0;
		end else if (finish_fire) begin
			hash_q <= '0;
			pos_q  <= '0;
		end else if (load_sum) begin
			hash_q <= reduced;
			pos_q  <= pos_q + 32'd1;
		end else if (load_prod) begin
			hash_q <= prod_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_fire) begin
			hash_value_q <= hash_q ^ HASH_FINAL_XOR;
		end
	end

	assign out_valid  = out_valid_q;
	assign hash_value = hash_value_q;

	`SPH_ASSERT(a_pos_only_in_update, (state_q != ST_REDUCE && state_q != ST_FINISH) |=> $stable(pos_q), "position changed outside update")
	`SPH_ASSERT(a_finish_clears, (state_q == ST_FINISH && out_free) |=> (out_valid && hash_q == 32'd0 && pos_q == 32'd0), "finish did not post result and clear state")
	`SPH_ASSERT(a_idle_item_stays, (in_fire && no_char && !end_of_string) |=> (in_ready && $stable(hash_q)), "idle item disturbed the hash")

endmodule

>>> rtl/core/sph_char_widen.sv
// character folding, slash mapping and widening to 32 bits
// depends on sph_pkg
module sph_char_widen
	import sph_pkg::*;
(
	input  sph_cfg_t    cfg,
	input  logic [7:0]  char_in,
	output logic [31:0] char_wide
);

	logic [7:0] mapped;

	always_comb begin
		priority if (cfg.hash_mode != MODE_PLAIN && char_in >= CHAR_UPPER_A &&
			char_in <= CHAR_UPPER_Z) begin
			mapped = char_in + CASE_OFFSET;
		end else if (cfg.hash_mode[1] && char_in == CHAR_SLASH) begin
			mapped = CHAR_BSLASH;
		end else begin
			mapped = char_in;
		end
	end

	assign char_wide = {{24{cfg.signed_chars & mapped[7]}}, mapped};

endmodule

>>> rtl/core/sph_mul.sv
// shared 32x32 multiplier keeping the low 32 bits, registered product
// no dependencies
module sph_mul (
	input  logic        clk,
	input  logic [31:0] op_a,
	input  logic [31:0] op_b,
	output logic [31:0] prod_q
);

	logic [31:0] full;

	assign full = op_a * op_b;

	always_ff @(posedge clk) begin
		prod_q <= full;
	end

endmodule
